>>> rtl/pep_pkg.sv
// ----------------------------------------------------------------------------
// pep_pkg
// Shared widths, register indexes and queue entry types of the edge projector.
// ----------------------------------------------------------------------------
package pep_pkg;

	localparam int CoordW   = 32;  // Q16.16 input coordinate
	localparam int ZW       = 31;  // accepted depth, always positive
	localparam int MagW     = 32;  // magnitude of z +/- x
	localparam int SizeW    = 14;  // window size register
	localparam int NearW    = 31;
	localparam int ProdW    = MagW + SizeW;
	localparam int RemW     = 48;  // holds z << DivSteps
	localparam int DivSteps = 17;  // quotient bits of floor(mag*size/z)
	localparam int QW       = DivSteps;
	localparam int PixW     = 16;
	localparam int Lanes    = 4;
	localparam int QDepth   = 4;
	localparam int QPtrW    = 2;
	localparam int QCntW    = 3;
	localparam int InW      = 6 * CoordW;
	localparam int OutW     = Lanes * PixW;
	localparam int CfgIdxW  = 2;
	localparam int CfgW     = 31;

	localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_NEAR   = 2'd2;

	localparam logic signed [PixW-1:0] PIX_MAX = 16'sh7FFF;
	localparam logic signed [PixW-1:0] PIX_MIN = -16'sh8000;

	// one coordinate: |numerator| and its sign
	typedef struct packed {
		logic [MagW-1:0] mag;
		logic            neg;
	} lane_t;

	// one classified edge; lanes: start x, start y, end x, end y
	typedef struct packed {
		lane_t [Lanes-1:0]   lane;
		logic  [1:0][ZW-1:0] z;
	} edge_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

>>> rtl/perspective_edge_projector.sv
// ----------------------------------------------------------------------------
// perspective_edge_projector
// Perspective divide and viewport mapping of line edges to window pixels.
// ----------------------------------------------------------------------------
// One edge per item, two Q16.16 endpoints. An edge with either depth at or
// below near_limit is dropped and yields nothing; otherwise each endpoint maps
// to px = width*(z+x)/(2z), py = height*(z-y)/(2z), rounded to nearest (ties
// away from zero) and saturated to 16 bits. One item per clock is sustained
// while m_tready is high; each item passes the front register, queue,
// multiply, 17 one-bit divide stages (one quotient bit per stage, four lanes)
// and output register before m_tvalid rises.
// The back pipeline stalls as a whole on m_tready; the 4-entry queue lets the
// front keep taking items meanwhile. Write registers only while idle.
module perspective_edge_projector (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// start_x, start_y, start_z, end_x, end_y, end_z (32 bits each, lowest first)
	input  logic [pep_pkg::InW-1:0]     s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// start_px, start_py, end_px, end_py (16 bits each, lowest first)
	output logic [pep_pkg::OutW-1:0]    m_tdata,
	input  logic                        cfg_we,
	input  logic [pep_pkg::CfgIdxW-1:0] cfg_idx,
	input  logic [pep_pkg::CfgW-1:0]    cfg_wdata
);
	import pep_pkg::*;

	logic [SizeW-1:0] width_q, height_q;
	logic [NearW-1:0] near_q;

	qstat_t qstat;
	logic   push, pop;
	edge_t  push_data, head;

	// register file; index three is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SizeW'(800);
			height_q <= SizeW'(600);
			near_q   <= NearW'(6554);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_WIDTH:  width_q  <= cfg_wdata[SizeW-1:0];
				CFG_HEIGHT: height_q <= cfg_wdata[SizeW-1:0];
				CFG_NEAR:   near_q   <= cfg_wdata[NearW-1:0];
				default:    ;
			endcase
		end
	end

	pep_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.near_limit(near_q), .qstat(qstat),
		.push(push), .push_data(push_data)
	);

	pep_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_data),
		.pop(pop), .head(head), .qstat(qstat)
	);

	pep_back u_back (
		.clk(clk), .arst_n(arst_n),
		.qstat(qstat), .head(head), .pop(pop),
		.window_width(width_q), .window_height(height_q),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

endmodule

>>> rtl/pep_front.sv
// ----------------------------------------------------------------------------
// pep_front
// Accepts edges, drops near ones, forms the numerators z+x and z-y.
// ----------------------------------------------------------------------------
module pep_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [pep_pkg::InW-1:0]   s_tdata,
	input  logic [pep_pkg::NearW-1:0] near_limit,
	input  pep_pkg::qstat_t           qstat,
	output logic                      push,
	output pep_pkg::edge_t            push_data
);
	import pep_pkg::*;

	logic  v_s1;
	logic  drop_s1;
	edge_t edge_s1;

	logic signed [CoordW-1:0] sx, sy, sz, ex, ey, ez;
	logic signed [CoordW:0]   num [Lanes];
	logic                     drop;
	edge_t                    cls;

	always_comb begin
		sx = s_tdata[0*CoordW +: CoordW];
		sy = s_tdata[1*CoordW +: CoordW];
		sz = s_tdata[2*CoordW +: CoordW];
		ex = s_tdata[3*CoordW +: CoordW];
		ey = s_tdata[4*CoordW +: CoordW];
		ez = s_tdata[5*CoordW +: CoordW];
		drop = (sz <= $signed({1'b0, near_limit})) || (ez <= $signed({1'b0, near_limit}));
		num[0] = {sz[CoordW-1], sz} + {sx[CoordW-1], sx};
		num[1] = {sz[CoordW-1], sz} - {sy[CoordW-1], sy};
		num[2] = {ez[CoordW-1], ez} + {ex[CoordW-1], ex};
		num[3] = {ez[CoordW-1], ez} - {ey[CoordW-1], ey};
		for (int c = 0; c < Lanes; c++) begin
			cls.lane[c].neg = num[c][CoordW];
			cls.lane[c].mag = num[c][CoordW] ? MagW'(-num[c]) : MagW'(num[c]);
		end
		cls.z[0] = sz[ZW-1:0];
		cls.z[1] = ez[ZW-1:0];
	end

	assign s_tready  = !v_s1 || drop_s1 || !qstat.full;
	assign push      = v_s1 && !drop_s1 && !qstat.full;
	assign push_data = edge_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			drop_s1 <= drop;
			edge_s1 <= cls;
		end
	end

endmodule

>>> rtl/pep_queue.sv
// ----------------------------------------------------------------------------
// pep_queue
// Short FIFO of classified edges between front and back.
// ----------------------------------------------------------------------------
module pep_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pep_pkg::edge_t  push_data,
	input  logic            pop,
	output pep_pkg::edge_t  head,
	output pep_pkg::qstat_t qstat
);
	import pep_pkg::*;

	edge_t            mem_q [QDepth];
	logic [QPtrW-1:0] wr_q, rd_q;
	logic [QCntW-1:0] cnt_q;

	assign qstat.full  = (cnt_q == QCntW'(QDepth));
	assign qstat.empty = (cnt_q == '0);
	assign head        = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + QCntW'(push) - QCntW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty) else $error("queue pop while empty");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count slip");
`endif

endmodule

>>> rtl/pep_back.sv
// ----------------------------------------------------------------------------
// pep_back
// Scaling multiply, pipelined restoring divide by depth, round and saturate.
// ----------------------------------------------------------------------------
module pep_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pep_pkg::qstat_t           qstat,
	input  pep_pkg::edge_t            head,
	output logic                      pop,
	input  logic [pep_pkg::SizeW-1:0] window_width,
	input  logic [pep_pkg::SizeW-1:0] window_height,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [pep_pkg::OutW-1:0]  m_tdata
);
	import pep_pkg::*;

	logic en;

	// multiply stage
	logic                  v_m_q;
	logic [RemW-1:0]       p_m_q   [Lanes];
	logic                  neg_m_q [Lanes];
	logic [1:0][ZW-1:0]    z_m_q;

	// divide stages
	logic                  v_d_q   [DivSteps];
	logic [RemW-1:0]       rem_d_q [DivSteps][Lanes];
	logic [QW-1:0]         t_d_q   [DivSteps][Lanes];
	logic                  ovf_d_q [DivSteps][Lanes];
	logic                  neg_d_q [DivSteps][Lanes];
	logic [1:0][ZW-1:0]    z_d_q   [DivSteps];

	logic [RemW-1:0]       rem_n   [DivSteps][Lanes];
	logic [QW-1:0]         t_n     [DivSteps][Lanes];
	logic                  ovf_n   [DivSteps][Lanes];

	logic                  v_out_q;
	logic [OutW-1:0]       out_q;
	logic [OutW-1:0]       pix;

	assign en       = !v_out_q || m_tready;
	assign pop      = en && !qstat.empty;
	assign m_tvalid = v_out_q;
	assign m_tdata  = out_q;

	always_comb begin
		logic [RemW-1:0] rem_s;
		logic [QW-1:0]   t_s;
		logic            ovf_s;
		logic [RemW-1:0] trial;
		logic [ZW-1:0]   zz;
		for (int k = 0; k < DivSteps; k++) begin
			for (int c = 0; c < Lanes; c++) begin
				if (k == 0) begin
					zz    = z_m_q[c >> 1];
					rem_s = p_m_q[c];
					t_s   = '0;
					ovf_s = p_m_q[c] >= (RemW'(zz) << DivSteps);
				end else begin
					zz    = z_d_q[k-1][c >> 1];
					rem_s = rem_d_q[k-1][c];
					t_s   = t_d_q[k-1][c];
					ovf_s = ovf_d_q[k-1][c];
				end
				trial = RemW'(zz) << (DivSteps - 1 - k);
				if (rem_s >= trial) begin
					rem_n[k][c] = rem_s - trial;
					t_n[k][c]   = t_s | (QW'(1) << (DivSteps - 1 - k));
				end else begin
					rem_n[k][c] = rem_s;
					t_n[k][c]   = t_s;
				end
				ovf_n[k][c] = ovf_s;
			end
		end
	end

	// round half up on floor(2n/d), then saturate
	always_comb begin
		logic [QW:0]   q1;
		logic [QW-1:0] q;
		logic          ng, ov;
		for (int c = 0; c < Lanes; c++) begin
			q1 = {1'b0, t_d_q[DivSteps-1][c]} + 1'b1;
			q  = q1[QW:1];
			ng = neg_d_q[DivSteps-1][c];
			ov = ovf_d_q[DivSteps-1][c];
			if (!ng) begin
				pix[c*PixW +: PixW] = (ov || q > QW'(32767)) ? PIX_MAX : q[PixW-1:0];
			end else begin
				pix[c*PixW +: PixW] = (ov || q > QW'(32768)) ? PIX_MIN : PixW'(-q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m_q   <= 1'b0;
			v_out_q <= 1'b0;
			for (int k = 0; k < DivSteps; k++) v_d_q[k] <= 1'b0;
		end else if (en) begin
			v_m_q    <= !qstat.empty;
			v_d_q[0] <= v_m_q;
			for (int k = 1; k < DivSteps; k++) v_d_q[k] <= v_d_q[k-1];
			v_out_q  <= v_d_q[DivSteps-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < Lanes; c++) begin
				p_m_q[c]   <= RemW'(ProdW'(head.lane[c].mag) *
					ProdW'(c[0] ? window_height : window_width));
				neg_m_q[c] <= head.lane[c].neg;
			end
			z_m_q <= head.z;
			for (int k = 0; k < DivSteps; k++) begin
				for (int c = 0; c < Lanes; c++) begin
					rem_d_q[k][c] <= rem_n[k][c];
					t_d_q[k][c]   <= t_n[k][c];
					ovf_d_q[k][c] <= ovf_n[k][c];
					neg_d_q[k][c] <= (k == 0) ? neg_m_q[c] : neg_d_q[k-1][c];
				end
				z_d_q[k] <= (k == 0) ? z_m_q : z_d_q[k-1];
			end
			out_q <= pix;
		end
	end

endmodule
